/* rtl/wem_pkg.sv */
// Package for the wheel encoder metrics block: widths, constants, types and helpers.
// Used by wem_mdu and wheel_encoder_metrics; depends on nothing.
package wem_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int SMOOTHING_DIV_DEF = 8;

    // Widths of the shared multiply/divide unit.
    localparam int NUM_W = 60;   // product and quotient
    localparam int MUL_W = 24;   // constant multiplier
    localparam int DIV_W = 40;   // divisor (scale register shifted by the fraction bits)
    localparam int CNT_W = 6;

    localparam int METRIC_MAX = 10000;
    localparam int AXIS_MAX   = 32767;
    localparam int ACC_GAIN   = 10000000;   // milliseconds per second times METRIC_MAX

    localparam logic [2:0] CFG_ENCODER_NEGATE = 3'd0;
    localparam logic [2:0] CFG_CENTER_AT_BOOT = 3'd1;
    localparam logic [2:0] CFG_FULL_LOCK      = 3'd2;
    localparam logic [2:0] CFG_VEL_SCALE      = 3'd3;
    localparam logic [2:0] CFG_ACC_SCALE      = 3'd4;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [MUL_W-1:0] mult;
        logic [DIV_W-1:0] divisor;
    } mdu_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } mdu_rsp_t;

    typedef enum logic [1:0] {
        MDU_IDLE,
        MDU_MUL,
        MDU_DIV
    } mdu_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PM,
        ST_AX,
        ST_VM,
        ST_AC1,
        ST_AC2,
        ST_FLT,
        ST_OUT
    } wem_state_t;

    // Clamp a magnitude to lim and apply the sign.
    function automatic logic signed [16:0] sat_mag(input logic [NUM_W-1:0] mag,
                                                  input logic neg,
                                                  input logic [15:0] lim);
        logic [15:0] m;
        m = (mag > NUM_W'(lim)) ? lim : mag[15:0];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

/* rtl/wem_mdu.sv */
// Bit-serial multiply by a constant followed by restoring division, on magnitudes.
// Depends on wem_pkg.
module wem_mdu (
    input  logic              aclk,
    input  logic              aresetn,
    input  wem_pkg::mdu_req_t req,
    output wem_pkg::mdu_rsp_t rsp
);

    wem_pkg::mdu_phase_t phase_reg, phase_next;

    logic [wem_pkg::NUM_W-1:0] acc_reg;
    logic [wem_pkg::NUM_W-1:0] mc_reg;
    logic [wem_pkg::MUL_W-1:0] k_reg;
    logic [wem_pkg::DIV_W-1:0] dv_reg;
    logic [wem_pkg::DIV_W-1:0] rem_reg;
    logic [wem_pkg::CNT_W-1:0] cnt_reg;
    logic                      done_reg;

    logic [wem_pkg::DIV_W:0]   trial;
    logic                      fits;

    assign trial = {rem_reg, acc_reg[wem_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, dv_reg};

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            wem_pkg::MDU_IDLE: begin
                if (req.start) phase_next = wem_pkg::MDU_MUL;
            end
            wem_pkg::MDU_MUL: begin
                if (cnt_reg == wem_pkg::CNT_W'(wem_pkg::MUL_W - 1)) phase_next = wem_pkg::MDU_DIV;
            end
            wem_pkg::MDU_DIV: begin
                if (cnt_reg == wem_pkg::CNT_W'(wem_pkg::NUM_W - 1)) phase_next = wem_pkg::MDU_IDLE;
            end
            default: phase_next = wem_pkg::MDU_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wem_pkg::MDU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == wem_pkg::MDU_DIV) &&
                         (cnt_reg == wem_pkg::CNT_W'(wem_pkg::NUM_W - 1));
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            wem_pkg::MDU_IDLE: begin
                acc_reg <= '0;
                mc_reg  <= req.dividend;
                k_reg   <= req.mult;
                dv_reg  <= req.divisor;
                cnt_reg <= '0;
                rem_reg <= '0;
            end
            wem_pkg::MDU_MUL: begin
                if (k_reg[0]) acc_reg <= acc_reg + mc_reg;
                mc_reg <= mc_reg << 1;
                k_reg  <= k_reg >> 1;
                if (cnt_reg == wem_pkg::CNT_W'(wem_pkg::MUL_W - 1)) cnt_reg <= '0;
                else cnt_reg <= cnt_reg + 1'b1;
            end
            wem_pkg::MDU_DIV: begin
                if (fits) rem_reg <= wem_pkg::DIV_W'(trial - {1'b0, dv_reg});
                else rem_reg <= trial[wem_pkg::DIV_W-1:0];
                acc_reg <= {acc_reg[wem_pkg::NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: cnt_reg <= '0;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.quot = acc_reg;

endmodule

/* rtl/wheel_encoder_metrics.sv */
// Top level of the wheel encoder metrics block.
// Depends on wem_pkg and wem_mdu.
//
// One encoder sample enters on the s_ stream: s_tdata carries raw position,
// raw velocity and the millisecond tick; s_tuser carries the encoder-live,
// recenter and enable flags. One result leaves on the m_ stream with the
// position, velocity and acceleration metrics and the wheel axis.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata) and
// must only be used while the block is idle.
//
// All scaling runs through one shared bit-serial unit that multiplies by a
// constant and then divides. A sample needs three operations (position,
// axis, velocity), plus three more when the acceleration filter updates.
// The block works on one item at a time; s_tready is high while it is idle.
// A finished result sits in the output register until it is taken, and the
// block still accepts the next item meanwhile; that item's result waits for
// the register to free up. Reset returns the configuration registers to
// their defaults and clears the center, the filter and the seeded flag.
module wheel_encoder_metrics #(
    parameter int FRACTION_BITS     = wem_pkg::FRACTION_BITS_DEF,
    parameter int SMOOTHING_DIVISOR = wem_pkg::SMOOTHING_DIV_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // raw_position, raw_velocity, tick_ms
    input  logic [2:0]  s_tuser,   // encoder_live, recenter_request, metrics_enable
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // position_metric, velocity_metric, accel_metric, wheel_axis
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int NW = wem_pkg::NUM_W;
    localparam int DW = wem_pkg::DIV_W;

    // Configuration registers.
    logic        negate_reg;
    logic        cab_reg;
    logic [7:0]  lock_reg;
    logic [9:0]  vscale_reg;
    logic [15:0] ascale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            negate_reg <= 1'b0;
            cab_reg    <= 1'b1;
            lock_reg   <= 8'd16;
            vscale_reg <= 10'd80;
            ascale_reg <= 16'd800;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wem_pkg::CFG_ENCODER_NEGATE: negate_reg <= cfg_wdata[0];
                wem_pkg::CFG_CENTER_AT_BOOT: cab_reg    <= cfg_wdata[0];
                wem_pkg::CFG_FULL_LOCK:      lock_reg   <= cfg_wdata[7:0];
                wem_pkg::CFG_VEL_SCALE:      vscale_reg <= cfg_wdata[9:0];
                wem_pkg::CFG_ACC_SCALE:      ascale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A scale register of zero counts as one.
    logic [DW-1:0] lock_fx, vel_fx, acc_fx;
    assign lock_fx = DW'((lock_reg == '0) ? 8'd1 : lock_reg) << FRACTION_BITS;
    assign vel_fx  = DW'((vscale_reg == '0) ? 10'd1 : vscale_reg) << FRACTION_BITS;
    assign acc_fx  = DW'((ascale_reg == '0) ? 16'd1 : ascale_reg) << FRACTION_BITS;

    // Input fields.
    logic signed [31:0] raw_pos, raw_vel;
    logic [31:0]        now;
    logic               live, recenter, enable;
    assign raw_pos  = s_tdata[31:0];
    assign raw_vel  = s_tdata[63:32];
    assign now      = s_tdata[95:64];
    assign live     = s_tuser[0];
    assign recenter = s_tuser[1];
    assign enable   = s_tuser[2];

    // Block state.
    wem_pkg::wem_state_t state_reg, state_next;
    logic signed [31:0] center_reg;
    logic               live_seen_reg;
    logic signed [33:0] prev_vel_reg;
    logic [31:0]        prev_tick_reg;
    logic signed [14:0] filt_reg;
    logic               seeded_reg;

    // Per-item working registers.
    logic signed [33:0] pos_reg, vel_reg;
    logic [31:0]        now_reg;
    logic               doacc_reg, first_reg, issued_reg;
    logic [NW-1:0]      q1_reg;
    logic signed [16:0] a_reg;
    logic signed [14:0] pm_reg, vm_reg;
    logic signed [15:0] ax_reg;
    logic               m_valid_reg;
    logic [63:0]        m_data_reg;

    logic s_acc;
    assign s_tready = (state_reg == wem_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Centering and sign correction at acceptance.
    logic signed [31:0] center_sel;
    logic signed [33:0] diff, pos_in, vel_in;
    assign center_sel = (recenter || (cab_reg && live && !live_seen_reg)) ? raw_pos : center_reg;
    assign diff   = 34'(raw_pos) - 34'(center_sel);
    assign pos_in = negate_reg ? -diff : diff;
    assign vel_in = negate_reg ? -34'(raw_vel) : 34'(raw_vel);

    // Magnitudes fed to the serial unit.
    logic [33:0]        pos_mag, vel_mag;
    logic signed [35:0] dv;
    logic [35:0]        dv_mag;
    logic signed [17:0] fd;
    logic [17:0]        fd_mag;
    logic [31:0]        dt;
    assign pos_mag = pos_reg[33] ? 34'(-pos_reg) : 34'(pos_reg);
    assign vel_mag = vel_reg[33] ? 34'(-vel_reg) : 34'(vel_reg);
    assign dv      = 36'(vel_reg) - 36'(prev_vel_reg);
    assign dv_mag  = dv[35] ? 36'(-dv) : 36'(dv);
    assign fd      = 18'(a_reg) - 18'(filt_reg);
    assign fd_mag  = fd[17] ? 18'(-fd) : 18'(fd);
    assign dt      = now_reg - prev_tick_reg;

    wem_pkg::mdu_req_t req;
    wem_pkg::mdu_rsp_t rsp;

    wem_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    logic               out_free;
    logic signed [16:0] sat_q;
    logic [NW-1:0]      fq;
    assign out_free = !m_valid_reg || m_tready;

    // Sequencer: next state and the request to the serial unit.
    always_comb begin
        state_next   = state_reg;
        req.start    = 1'b0;
        req.dividend = '0;
        req.mult     = wem_pkg::MUL_W'(1);
        req.divisor  = lock_fx;
        case (state_reg)
            wem_pkg::ST_IDLE: begin
                if (s_acc) state_next = wem_pkg::ST_PM;
            end
            wem_pkg::ST_PM: begin
                req.start    = !issued_reg;
                req.dividend = NW'(pos_mag);
                req.mult     = wem_pkg::MUL_W'(wem_pkg::METRIC_MAX);
                if (rsp.done) state_next = wem_pkg::ST_AX;
            end
            wem_pkg::ST_AX: begin
                req.start    = !issued_reg;
                req.dividend = NW'(pos_mag);
                req.mult     = wem_pkg::MUL_W'(wem_pkg::AXIS_MAX);
                if (rsp.done) state_next = wem_pkg::ST_VM;
            end
            wem_pkg::ST_VM: begin
                req.start    = !issued_reg;
                req.dividend = NW'(vel_mag);
                req.mult     = wem_pkg::MUL_W'(wem_pkg::METRIC_MAX);
                req.divisor  = vel_fx;
                if (rsp.done) state_next = doacc_reg ? wem_pkg::ST_AC1 : wem_pkg::ST_OUT;
            end
            wem_pkg::ST_AC1: begin
                req.start    = !issued_reg;
                req.dividend = NW'(dv_mag);
                req.mult     = wem_pkg::MUL_W'(wem_pkg::ACC_GAIN);
                req.divisor  = acc_fx;
                if (rsp.done) state_next = wem_pkg::ST_AC2;
            end
            wem_pkg::ST_AC2: begin
                req.start    = !issued_reg;
                req.dividend = q1_reg;
                req.divisor  = DW'(dt);
                if (rsp.done) state_next = wem_pkg::ST_FLT;
            end
            wem_pkg::ST_FLT: begin
                req.start    = !issued_reg;
                req.dividend = NW'(fd_mag);
                req.divisor  = DW'(SMOOTHING_DIVISOR);
                if (rsp.done) state_next = wem_pkg::ST_OUT;
            end
            wem_pkg::ST_OUT: begin
                if (out_free) state_next = wem_pkg::ST_IDLE;
            end
            default: state_next = wem_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= wem_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    assign sat_q = wem_pkg::sat_mag(rsp.quot, 1'b0, 16'(wem_pkg::METRIC_MAX));
    assign fq    = rsp.quot;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg    <= '0;
            live_seen_reg <= 1'b0;
            prev_vel_reg  <= '0;
            prev_tick_reg <= '0;
            filt_reg      <= '0;
            seeded_reg    <= 1'b0;
            issued_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (req.start) issued_reg <= 1'b1;
            else if (rsp.done) issued_reg <= 1'b0;

            if (s_acc) begin
                center_reg    <= center_sel;
                live_seen_reg <= live;
                if (enable && !seeded_reg) begin
                    prev_vel_reg  <= vel_in;
                    prev_tick_reg <= now;
                    seeded_reg    <= 1'b1;
                end
            end

            if (state_reg == wem_pkg::ST_FLT && rsp.done) begin
                // The filter steps by the difference divided by the smoothing
                // divisor, truncated toward zero.
                filt_reg      <= fd[17] ? filt_reg - 15'(fq) : filt_reg + 15'(fq);
                prev_vel_reg  <= vel_reg;
                prev_tick_reg <= now_reg;
            end

            if (state_reg == wem_pkg::ST_OUT && out_free) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pos_reg   <= pos_in;
            vel_reg   <= vel_in;
            now_reg   <= now;
            first_reg <= enable && !seeded_reg;
            doacc_reg <= enable && seeded_reg && (now != prev_tick_reg);
        end
        if (rsp.done) begin
            case (state_reg)
                wem_pkg::ST_PM: pm_reg <= 15'(wem_pkg::sat_mag(rsp.quot, pos_reg[33],
                                                              16'(wem_pkg::METRIC_MAX)));
                wem_pkg::ST_AX: ax_reg <= 16'(wem_pkg::sat_mag(rsp.quot, pos_reg[33],
                                                              16'(wem_pkg::AXIS_MAX)));
                wem_pkg::ST_VM: vm_reg <= 15'(wem_pkg::sat_mag(rsp.quot, vel_reg[33],
                                                              16'(wem_pkg::METRIC_MAX)));
                wem_pkg::ST_AC1: q1_reg <= rsp.quot;
                wem_pkg::ST_AC2: a_reg  <= dv[35] ? -sat_q : sat_q;
                default: ;
            endcase
        end
        if (state_reg == wem_pkg::ST_OUT && out_free) begin
            m_data_reg <= {3'b000, ax_reg, (first_reg ? 15'sd0 : filt_reg), vm_reg, pm_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* test/testbench.sv */
// Self-checking testbench for wheel_encoder_metrics: encoder samples in, metric items out.
// Predicts each result in SystemVerilog and compares field by field.
// Depends on wem_pkg and the wheel_encoder_metrics RTL.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic        enable;
        logic        recenter;
        logic        live;
        logic [31:0] tick;
        logic [31:0] velocity;
        logic [31:0] position;
    } sample_t;

    typedef struct packed {
        logic [15:0] axis;
        logic [14:0] accel;
        logic [14:0] velocity;
        logic [14:0] position;
    } metrics_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    wheel_encoder_metrics dut (.*);

    always #10 aclk = ~aclk;

    // Shadow of the configuration registers.
    logic        negate_cfg;
    logic        boot_center_cfg;
    logic [7:0]  lock_turns_cfg;
    logic [9:0]  vel_scale_cfg;
    logic [15:0] acc_scale_cfg;

    // Shadow of the block's state.
    longint      center_pos;
    bit          live_prev;
    longint      last_vel;
    logic [31:0] last_tick;
    longint      filt;
    bit          seeded;

    sample_t  pending_samples[$];
    metrics_t expected_metrics[$];
    int       error_count = 0;
    bit       quiet_tail = 1'b0;
    bit       hold_receiver = 1'b0;
    int       hold_count = 0;
    int       rx_gap = 0;
    int       tx_gap = 0;
    longint   cycle_count = 0;

    // Clamp v to the range -lim to lim (SystemVerilog longint division truncates toward zero).
    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic metrics_t predict_metrics(sample_t s);
        longint rp, pos, vel, lock_fx, vfx, afx, dt, a;
        metrics_t r;
        rp = longint'($signed(s.position));
        if (s.recenter || (boot_center_cfg && s.live && !live_prev)) center_pos = rp;
        live_prev = s.live;
        pos = rp - center_pos;
        vel = longint'($signed(s.velocity));
        if (negate_cfg) begin
            pos = -pos;
            vel = -vel;
        end
        lock_fx = longint'(lock_turns_cfg == 0 ? 1 : lock_turns_cfg) << 16;
        vfx = longint'(vel_scale_cfg == 0 ? 1 : vel_scale_cfg) << 16;
        afx = longint'(acc_scale_cfg == 0 ? 1 : acc_scale_cfg) << 16;
        r.position = 15'(clamp(pos * 10000 / lock_fx, 10000));
        r.velocity = 15'(clamp(vel * 10000 / vfx, 10000));
        r.axis = 16'(clamp(pos * 32767 / lock_fx, 32767));
        r.accel = 15'(filt);
        if (s.enable) begin
            if (!seeded) begin
                last_vel = vel;
                last_tick = s.tick;
                seeded = 1'b1;
                r.accel = '0;
            end else begin
                if (s.tick != last_tick) begin
                    dt = longint'(32'(s.tick - last_tick));
                    a = clamp(((vel - last_vel) * 10000000 / afx) / dt, 10000);
                    filt = filt + (a - filt) / 8;
                    last_vel = vel;
                    last_tick = s.tick;
                end
                r.accel = 15'(filt);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            wem_pkg::CFG_ENCODER_NEGATE: negate_cfg = val[0];
            wem_pkg::CFG_CENTER_AT_BOOT: boot_center_cfg = val[0];
            wem_pkg::CFG_FULL_LOCK:      lock_turns_cfg = val[7:0];
            wem_pkg::CFG_VEL_SCALE:      vel_scale_cfg = val[9:0];
            default:                     acc_scale_cfg = val;
        endcase
    endtask

    // Queue a sample and its prediction together, so predictions follow input order.
    task automatic queue_sample(sample_t s);
        pending_samples.push_back(s);
        expected_metrics.push_back(predict_metrics(s));
    endtask

    // Waits for the block to drain every item, then a margin for the pipeline.
    task automatic wait_drained();
        wait (pending_samples.size() == 0 && expected_metrics.size() == 0);
        repeat (600) @(posedge aclk);
    endtask

    function automatic sample_t random_sample(logic [31:0] tick);
        sample_t s;
        s.position = $urandom_range(0, 3) == 0 ? $urandom()
                     : 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        s.velocity = $urandom_range(0, 3) == 0 ? $urandom()
                     : 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
        s.tick = tick;
        s.live = $urandom_range(0, 9) != 0;
        s.recenter = $urandom_range(0, 29) == 0;
        s.enable = $urandom_range(0, 7) != 0;
        return s;
    endfunction

    // Driver: offers items from the pending queue, with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the offered item
        end else begin
            if (s_tvalid) void'(pending_samples.pop_front());
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0
                         && (quiet_tail || $urandom_range(0, 5) != 0)) begin
                sample_t nx;
                nx = pending_samples[0];
                s_tvalid <= 1'b1;
                s_tdata <= {nx.tick, nx.velocity, nx.position};
                s_tuser <= {nx.enable, nx.recenter, nx.live};
            end else begin
                s_tvalid <= 1'b0;
                if (!quiet_tail && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 18);
            end
        end
    end

    // Long receiver hold-off, counted in cycles, so the output register fills
    // and the input stalls.
    always @(posedge aclk) begin
        if (hold_receiver) begin
            hold_count <= hold_count + 1;
            if (hold_count >= 3000) begin
                hold_receiver <= 1'b0;
                hold_count <= 0;
            end
        end
    end

    // Monitor: checks each accepted result and drives m_tready with stalls.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            metrics_t got, want;
            got = m_tdata[60:0];
            if (expected_metrics.size() == 0) begin
                $display("result with no expectation waiting: %0h", m_tdata);
                error_count++;
            end else begin
                want = expected_metrics.pop_front();
                if (got.position !== want.position)
                    report_mismatch("position_metric", 16'(got.position), 16'(want.position));
                if (got.velocity !== want.velocity)
                    report_mismatch("velocity_metric", 16'(got.velocity), 16'(want.velocity));
                if (got.accel !== want.accel)
                    report_mismatch("accel_metric", 16'(got.accel), 16'(want.accel));
                if (got.axis !== want.axis)
                    report_mismatch("wheel_axis", got.axis, want.axis);
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_receiver) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_gap <= $urandom_range(1, 18);
        end else begin
            m_tready <= 1'b1;
        end
        if (cycle_count > 4000000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        sample_t s;
        logic [31:0] tick;
        int n;
        negate_cfg = 1'b0;
        boot_center_cfg = 1'b1;
        lock_turns_cfg = 8'd16;
        vel_scale_cfg = 10'd80;
        acc_scale_cfg = 16'd800;
        center_pos = 0;
        live_prev = 1'b0;
        last_vel = 0;
        last_tick = '0;
        filt = 0;
        seeded = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: enable off, first enabled seed, boot centering, same tick,
        // tick wrap, field extremes, recenter.
        s = '0; s.position = 32'h0001_0000; queue_sample(s);
        s.live = 1'b1; s.position = 32'h0005_0000; queue_sample(s);
        s.enable = 1'b1; s.tick = 32'hFFFF_FFFE; s.velocity = 32'h0010_0000; queue_sample(s);
        s.tick = 32'hFFFF_FFFE; s.velocity = 32'h0020_0000; queue_sample(s);
        s.tick = 32'h0000_0001; s.velocity = 32'h7FFF_FFFF; queue_sample(s);
        s.tick = 32'h0000_0002; s.velocity = 32'h8000_0000; s.position = 32'h7FFF_FFFF;
        queue_sample(s);
        s.tick = 3; s.position = 32'h8000_0000; queue_sample(s);
        s.recenter = 1'b1; s.tick = 4; s.position = 32'hFFFF_FFFF; s.velocity = 0;
        queue_sample(s);
        s.recenter = 1'b0; s.enable = 1'b0; s.tick = 5; s.position = 32'h0100_0000;
        queue_sample(s);
        s.live = 1'b0; s.tick = 32'hFFFF_FFFF; queue_sample(s);
        s.live = 1'b1; s.enable = 1'b1; s.tick = 6; s.position = 32'h0200_0000;
        queue_sample(s);
        wait_drained();

        // Extreme settings, including a zero full-lock register treated as one.
        write_reg(wem_pkg::CFG_ENCODER_NEGATE, 16'd1);
        write_reg(wem_pkg::CFG_CENTER_AT_BOOT, 16'd0);
        write_reg(wem_pkg::CFG_FULL_LOCK, 16'd0);
        write_reg(wem_pkg::CFG_VEL_SCALE, 16'd1);
        write_reg(wem_pkg::CFG_ACC_SCALE, 16'd1);
        tick = 100;
        for (int i = 0; i < 10; i++) begin
            s = random_sample(tick);
            s.live = i[0];
            queue_sample(s);
            tick += $urandom_range(0, 2);
        end
        wait_drained();

        // Random phases over several settings; the first phase holds off the receiver.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) quiet_tail = 1'b1;
            case (phase)
                0: begin
                    write_reg(wem_pkg::CFG_ENCODER_NEGATE, 16'd0);
                    write_reg(wem_pkg::CFG_CENTER_AT_BOOT, 16'd1);
                    write_reg(wem_pkg::CFG_FULL_LOCK, 16'd16);
                    write_reg(wem_pkg::CFG_VEL_SCALE, 16'd80);
                    write_reg(wem_pkg::CFG_ACC_SCALE, 16'd800);
                end
                1: begin
                    write_reg(wem_pkg::CFG_FULL_LOCK, 16'd255);
                    write_reg(wem_pkg::CFG_VEL_SCALE, 16'd1023);
                    write_reg(wem_pkg::CFG_ACC_SCALE, 16'd65535);
                end
                2: begin
                    write_reg(wem_pkg::CFG_ENCODER_NEGATE, 16'd1);
                    write_reg(wem_pkg::CFG_FULL_LOCK, 16'd1);
                    write_reg(wem_pkg::CFG_VEL_SCALE, 16'd0);
                    write_reg(wem_pkg::CFG_ACC_SCALE, 16'd0);
                end
                default: begin
                    write_reg(wem_pkg::CFG_ENCODER_NEGATE, 16'($urandom_range(0, 1)));
                    write_reg(wem_pkg::CFG_CENTER_AT_BOOT, 16'($urandom_range(0, 1)));
                    write_reg(wem_pkg::CFG_FULL_LOCK, 16'($urandom_range(1, 255)));
                    write_reg(wem_pkg::CFG_VEL_SCALE, 16'($urandom_range(1, 1023)));
                    write_reg(wem_pkg::CFG_ACC_SCALE, 16'($urandom_range(1, 65535)));
                end
            endcase
            if (phase == 0) hold_receiver = 1'b1;
            n = 220;
            tick = $urandom();
            for (int i = 0; i < n; i++) begin
                queue_sample(random_sample(tick));
                tick += ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 3);
            end
            wait_drained();
        end
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/wem_pkg.sv
rtl/wem_mdu.sv
rtl/wheel_encoder_metrics.sv
test/testbench.sv
